@@ rtl/core/nearest_palette_colour_search_core_defines.svh @@
// Assertion macros shared by the nearest palette colour search checker.
// No dependencies; include by bare file name.
`ifndef NEAREST_PALETTE_COLOUR_SEARCH_CORE_DEFINES_SVH
`define NEAREST_PALETTE_COLOUR_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, clocked on rising edge, disabled in reset
`define NPCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("npcs check failed");

// Next-cycle implication, clocked on rising edge, disabled in reset
`define NPCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("npcs check failed");

`endif

@@ rtl/core/npcs_pkg.sv @@
// Shared types, constants and codes for the nearest palette colour search core.
// No dependencies.
package npcs_pkg;

	// Field widths
	localparam int COLOR_W   = 8;
	localparam int INDEX_W   = 8;
	localparam int ENTRY_W   = 3 * COLOR_W;
	localparam int SQ_W      = 2 * COLOR_W;
	localparam int DIST_W    = SQ_W + 2;

	// Palette depth default and search start bound (3 * 256^2)
	localparam int DEFAULT_ENTRIES = 256;
	localparam logic [DIST_W-1:0] START_BOUND = DIST_W'(3 * 256 * 256);

	// Operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DELIVER
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic write_entry;
		logic start_query;
		logic scan_step;
		logic load_out;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic addr_last;
		logic scan_done;
		logic out_free;
	} dp_status_t;

endpackage

@@ rtl/core/npcs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module npcs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/core/npcs_datapath.sv @@
// Datapath: palette RAM with entry valid bits, scan address counter,
// distance pipeline, best-match tracking and output register. Uses npcs_pkg, npcs_ram.
module npcs_datapath #(
	parameter int PALETTE_ENTRIES = npcs_pkg::DEFAULT_ENTRIES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  npcs_pkg::dp_cmd_t             cmd,
	output npcs_pkg::dp_status_t          status,
	input  logic [npcs_pkg::INDEX_W-1:0]  entry_index,
	input  logic [npcs_pkg::COLOR_W-1:0]  red,
	input  logic [npcs_pkg::COLOR_W-1:0]  green,
	input  logic [npcs_pkg::COLOR_W-1:0]  blue,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [npcs_pkg::INDEX_W-1:0]  best_index
);
	import npcs_pkg::*;

	localparam int AW = $clog2(PALETTE_ENTRIES);

	logic                 wr_in_range;
	logic                 wr_en;
	logic [AW-1:0]        addr_q;
	logic [PALETTE_ENTRIES-1:0] entry_valid_q;
	logic [ENTRY_W-1:0]   rd_data;
	logic [COLOR_W-1:0]   qr_q, qg_q, qb_q;

	logic                 live_s1, last_s1, valid_s1;
	logic [AW-1:0]        idx_s1;
	logic [ENTRY_W-1:0]   pix;
	logic [COLOR_W-1:0]   dr, dg, db;

	logic                 live_s2, last_s2;
	logic [AW-1:0]        idx_s2;
	logic [SQ_W-1:0]      sq_r_s2, sq_g_s2, sq_b_s2;
	logic [DIST_W-1:0]    sq_sum;

	logic [DIST_W-1:0]    min_sum_q;
	logic [AW-1:0]        best_idx_q;
	logic                 scan_done_q;
	logic                 out_valid_q;
	logic [INDEX_W-1:0]   out_idx_q;

	// Writes beyond the palette are dropped
	assign wr_in_range = {1'b0, entry_index} < (INDEX_W + 1)'(PALETTE_ENTRIES);
	assign wr_en       = cmd.write_entry && wr_in_range;

	npcs_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (entry_index[AW-1:0]),
		.wr_data ({red, green, blue}),
		.rd_en   (cmd.scan_step),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	// Entry valid bits: an unwritten entry reads as black
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
		end else if (wr_en) begin
			entry_valid_q[entry_index[AW-1:0]] <= 1'b1;
		end
	end

	// Query colour capture
	always_ff @(posedge clk) begin
		if (cmd.start_query) begin
			qr_q <= red;
			qg_q <= green;
			qb_q <= blue;
		end
	end

	// Scan address counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cmd.start_query) begin
			addr_q <= '0;
		end else if (cmd.scan_step) begin
			addr_q <= addr_q + AW'(1);
		end
	end

	// Stage 1: RAM read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			live_s1 <= cmd.scan_step;
			last_s1 <= cmd.scan_step && status.addr_last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			idx_s1   <= addr_q;
			valid_s1 <= entry_valid_q[addr_q];
		end
	end

	// Absolute component differences
	assign pix = valid_s1 ? rd_data : '0;
	assign dr  = (qr_q >= pix[2*COLOR_W +: COLOR_W]) ? qr_q - pix[2*COLOR_W +: COLOR_W]
	                                                 : pix[2*COLOR_W +: COLOR_W] - qr_q;
	assign dg  = (qg_q >= pix[COLOR_W +: COLOR_W]) ? qg_q - pix[COLOR_W +: COLOR_W]
	                                               : pix[COLOR_W +: COLOR_W] - qg_q;
	assign db  = (qb_q >= pix[0 +: COLOR_W]) ? qb_q - pix[0 +: COLOR_W]
	                                         : pix[0 +: COLOR_W] - qb_q;

	// Stage 2: squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_s2 <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			live_s2 <= live_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (live_s1) begin
			idx_s2  <= idx_s1;
			sq_r_s2 <= SQ_W'(dr) * SQ_W'(dr);
			sq_g_s2 <= SQ_W'(dg) * SQ_W'(dg);
			sq_b_s2 <= SQ_W'(db) * SQ_W'(db);
		end
	end

	// Sum and strict compare: ties keep the lower index
	assign sq_sum = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);

	always_ff @(posedge clk) begin
		if (cmd.start_query) begin
			min_sum_q  <= START_BOUND;
			best_idx_q <= '0;
		end else if (live_s2 && (sq_sum < min_sum_q)) begin
			min_sum_q  <= sq_sum;
			best_idx_q <= idx_s2;
		end
	end

	// Pulse once the last entry has been compared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_done_q <= 1'b0;
		end else begin
			scan_done_q <= live_s2 && last_s2;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_idx_q <= INDEX_W'(best_idx_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign best_index = out_idx_q;

	assign status.addr_last = (addr_q == AW'(PALETTE_ENTRIES - 1));
	assign status.scan_done = scan_done_q;
	assign status.out_free  = !out_valid_q || !out_stall;

endmodule

@@ rtl/core/npcs_ctrl.sv @@
// Controller state machine: accepts items, sequences the palette scan
// and hands the result to the output register. Uses npcs_pkg.
module npcs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 operation,
	output logic                 in_stall,
	input  npcs_pkg::dp_status_t status,
	output npcs_pkg::dp_cmd_t    cmd
);
	import npcs_pkg::*;

	state_t state_q, state_nxt;
	logic   accept;

	assign accept = in_valid && (state_q == ST_IDLE);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && operation == OP_QUERY) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.addr_last) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (status.scan_done) state_nxt = ST_DELIVER;
			end
			ST_DELIVER: begin
				if (status.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall        = 1'b0;
				cmd.write_entry = accept && operation == OP_WRITE;
				cmd.start_query = accept && operation == OP_QUERY;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_DELIVER: begin
				cmd.load_out = status.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/core/nearest_palette_colour_search_core.sv @@
// Nearest palette colour search. Holds a palette of PALETTE_ENTRIES RGB entries
// (8 bits per component, all black after reset). A write transfer stores one
// entry and gives no result; an index at or above PALETTE_ENTRIES is dropped.
// A query transfer returns the index of the entry with the least squared RGB
// distance, lowest index on ties. The result passes through one palette RAM
// read per entry on its single read port, the square stage, the final compare,
// the hand-off to the controller and the result load. The next item can
// transfer in the cycle after the load; the load waits while the previous
// result is still held in the output register. in_stall stays high while a
// query is in progress. Uses npcs_pkg, npcs_ctrl, npcs_datapath.
module nearest_palette_colour_search_core #(
	parameter int PALETTE_ENTRIES = npcs_pkg::DEFAULT_ENTRIES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         operation,
	input  logic [npcs_pkg::INDEX_W-1:0] entry_index,
	input  logic [npcs_pkg::COLOR_W-1:0] red,
	input  logic [npcs_pkg::COLOR_W-1:0] green,
	input  logic [npcs_pkg::COLOR_W-1:0] blue,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [npcs_pkg::INDEX_W-1:0] best_index
);
	import npcs_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	npcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_stall  (in_stall),
		.status    (status),
		.cmd       (cmd)
	);

	npcs_datapath #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.entry_index (entry_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.best_index  (best_index)
	);

endmodule

@@ rtl/core/npcs_checker.sv @@
// Port-level checks for the nearest palette colour search core, bound to the top.
// Uses npcs_pkg and nearest_palette_colour_search_core_defines.svh.
`include "nearest_palette_colour_search_core_defines.svh"

module npcs_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         operation,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [npcs_pkg::INDEX_W-1:0] best_index
);
	import npcs_pkg::*;

	// A held result stays offered
	`NPCS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// A held result keeps its index
	`NPCS_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(best_index))

	// A query transfer makes the block busy
	`NPCS_ASSERT_NEXT(a_query_busy, clk, arst_n, in_valid && !in_stall && operation == OP_QUERY, in_stall)

	// A write transfer leaves the block free to accept in the next cycle
	`NPCS_ASSERT_NEXT(a_write_free, clk, arst_n, in_valid && !in_stall && operation == OP_WRITE, !in_stall)

endmodule

bind nearest_palette_colour_search_core npcs_checker u_checker (.*);

@@ dv/tb_nearest_palette_colour_search_core.sv @@
// Self-checking testbench for nearest_palette_colour_search_core: directed and random
// palette writes and nearest-colour queries, checked against a shadow palette model.
// Depends on npcs_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_nearest_palette_colour_search_core;
	import npcs_pkg::*;

	localparam int ENTRIES      = DEFAULT_ENTRIES;
	localparam int TARGET_ITEMS = 1350;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int DRAIN_CYCLES = ENTRIES + 44;

	typedef struct packed {
		logic [COLOR_W-1:0] r;
		logic [COLOR_W-1:0] g;
		logic [COLOR_W-1:0] b;
	} rgb_t;

	typedef enum int {STYLE_ANY, STYLE_LEVELS, STYLE_EXTREME, STYLE_GREY} colour_style_t;
	typedef enum int {QUERY_ANY, QUERY_COPY, QUERY_NEAR, QUERY_EXTREME} query_kind_t;
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               operation   = OP_WRITE;
	logic [INDEX_W-1:0] entry_index = '0;
	logic [COLOR_W-1:0] red         = '0;
	logic [COLOR_W-1:0] green       = '0;
	logic [COLOR_W-1:0] blue        = '0;
	logic               out_stall   = 1'b0;
	logic               in_stall;
	logic               out_valid;
	logic [INDEX_W-1:0] best_index;

	// Shadow palette and queue of expected best indexes
	rgb_t               palette_shadow [ENTRIES];
	logic [INDEX_W-1:0] expected_best_q [$];

	int mismatch_count = 0;
	int items_sent     = 0;
	int burst_left     = 0;
	int cycle_count    = 0;

	stall_mode_t stall_mode      = STALL_NONE;
	int          stall_mode_left = 0;
	int          stall_phase     = 0;

	nearest_palette_colour_search_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.entry_index (entry_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.best_index  (best_index)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Nearest entry by squared RGB distance; strict compare keeps lowest index on ties
	function automatic logic [INDEX_W-1:0] nearest_entry(rgb_t c);
		int min_sum;
		int sum_sq;
		int dr;
		int dg;
		int db;
		int i;
		logic [INDEX_W-1:0] best;
		min_sum = int'(START_BOUND);
		best = '0;
		for (i = 0; i < ENTRIES; i++) begin
			dr = int'(c.r) - int'(palette_shadow[i].r);
			dg = int'(c.g) - int'(palette_shadow[i].g);
			db = int'(c.b) - int'(palette_shadow[i].b);
			sum_sq = dr * dr + dg * dg + db * db;
			if (sum_sq < min_sum) begin
				min_sum = sum_sq;
				best = INDEX_W'(i);
			end
		end
		return best;
	endfunction

	function automatic logic [COLOR_W-1:0] nudge(logic [COLOR_W-1:0] v);
		int n;
		n = int'(v) + int'($urandom_range(0, 6)) - 3;
		if (n < 0) n = 0;
		if (n > 255) n = 255;
		return COLOR_W'(n);
	endfunction

	function automatic rgb_t random_colour(colour_style_t style);
		rgb_t c;
		logic [COLOR_W-1:0] v;
		case (style)
			STYLE_LEVELS: begin
				c.r = COLOR_W'(85 * $urandom_range(0, 3));
				c.g = COLOR_W'(85 * $urandom_range(0, 3));
				c.b = COLOR_W'(85 * $urandom_range(0, 3));
			end
			STYLE_EXTREME: begin
				c.r = COLOR_W'(255 * $urandom_range(0, 1));
				c.g = COLOR_W'(255 * $urandom_range(0, 1));
				c.b = COLOR_W'(255 * $urandom_range(0, 1));
			end
			STYLE_GREY: begin
				v = COLOR_W'($urandom_range(0, 255));
				c = {nudge(v), nudge(v), nudge(v)};
			end
			default: c = rgb_t'(ENTRY_W'($urandom));
		endcase
		return c;
	endfunction

	function automatic rgb_t query_colour(query_kind_t kind);
		rgb_t c;
		case (kind)
			QUERY_COPY:    c = palette_shadow[$urandom_range(0, ENTRIES - 1)];
			QUERY_NEAR: begin
				c = palette_shadow[$urandom_range(0, ENTRIES - 1)];
				c = {nudge(c.r), nudge(c.g), nudge(c.b)};
			end
			QUERY_EXTREME: c = random_colour(STYLE_EXTREME);
			default:       c = rgb_t'(ENTRY_W'($urandom));
		endcase
		return c;
	endfunction

	task automatic report_mismatch(input string what, input int want, input logic [INDEX_W-1:0] got);
		mismatch_count++;
		$display("mismatch: %s expected %0d got %0d (cycle %0d)", what, want, got, cycle_count);
	endtask

	// Send one item, with burst/gap pacing; update the model at the accepting edge
	task automatic send_item(input logic op, input logic [INDEX_W-1:0] idx, input rgb_t c);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
			                                          : $urandom_range(1, 30);
		end
		burst_left--;
		in_valid    <= 1'b1;
		operation   <= op;
		entry_index <= idx;
		red         <= c.r;
		green       <= c.g;
		blue        <= c.b;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (op == OP_WRITE) begin
			if (int'(idx) < ENTRIES) palette_shadow[idx] = c;
		end else begin
			expected_best_q.push_back(nearest_entry(c));
		end
	endtask

	// Output stall pattern: modes held for random stretches
	always @(posedge clk) begin
		if (stall_mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_mode_left = $urandom_range(50, 600);
		end
		stall_mode_left--;
		stall_phase++;
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
			default:     out_stall <= ((stall_phase % 23) < 9);
		endcase
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin : check_results
		logic [INDEX_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_best_q.size() == 0) begin
				report_mismatch("unexpected result", -1, best_index);
			end else begin
				want = expected_best_q.pop_front();
				if (best_index !== want) report_mismatch("best_index", int'(want), best_index);
			end
		end
	end

	// Timeout
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// All-black palette after reset: every query lands on entry 0
	task automatic test_reset_palette();
		send_item(OP_QUERY, 8'd0,   {8'h00, 8'h00, 8'h00});
		send_item(OP_QUERY, 8'd255, {8'hff, 8'hff, 8'hff});
	endtask

	// Extreme entries and colours; query ignores entry_index
	task automatic test_extreme_colours();
		send_item(OP_WRITE, 8'd255, {8'hff, 8'hff, 8'hff});
		send_item(OP_WRITE, 8'd128, {8'hff, 8'h00, 8'hff});
		send_item(OP_WRITE, 8'd1,   {8'h00, 8'hff, 8'h00});
		send_item(OP_QUERY, 8'd7,   {8'hff, 8'hff, 8'hff});
		send_item(OP_QUERY, 8'd255, {8'hff, 8'h00, 8'hff});
		send_item(OP_QUERY, 8'd128, {8'h00, 8'h00, 8'h00});
		send_item(OP_WRITE, 8'd0,   {8'hff, 8'hff, 8'hff});
		send_item(OP_QUERY, 8'd0,   {8'hff, 8'hff, 8'hff});
		send_item(OP_QUERY, 8'd0,   {8'h00, 8'h00, 8'h00});
		send_item(OP_QUERY, 8'd0,   {8'h00, 8'hff, 8'h00});
	endtask

	// Equal distances: lowest index must win
	task automatic test_tie_break();
		send_item(OP_WRITE, 8'd20, {8'h80, 8'h80, 8'h80});
		send_item(OP_WRITE, 8'd10, {8'h80, 8'h80, 8'h80});
		send_item(OP_QUERY, 8'd20, {8'h80, 8'h80, 8'h80});
		send_item(OP_QUERY, 8'd0,  {8'h90, 8'h80, 8'h80});
		send_item(OP_WRITE, 8'd30, {8'hc8, 8'h00, 8'h00});
		send_item(OP_WRITE, 8'd40, {8'h00, 8'hc8, 8'h00});
		send_item(OP_QUERY, 8'd0,  {8'h64, 8'h64, 8'h00});
	endtask

	// Full palette load, then bursts of writes and queries with varied colour styles
	task automatic test_random_traffic();
		colour_style_t style;
		int writes;
		int queries;
		int k;
		for (k = 0; k < ENTRIES; k++)
			send_item(OP_WRITE, INDEX_W'(k), random_colour(STYLE_ANY));
		while (items_sent < TARGET_ITEMS) begin
			style = colour_style_t'($urandom_range(0, 3));
			writes = $urandom_range(0, 24);
			repeat (writes)
				send_item(OP_WRITE, INDEX_W'($urandom_range(0, 255)), random_colour(style));
			queries = $urandom_range(1, 6);
			repeat (queries)
				send_item(OP_QUERY, INDEX_W'($urandom_range(0, 255)),
				          query_colour(query_kind_t'($urandom_range(0, 3))));
		end
	endtask

	initial begin
		int k;
		// Shadow palette matches the cleared palette after reset
		for (k = 0; k < ENTRIES; k++)
			palette_shadow[k] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_palette();
		test_extreme_colours();
		test_tie_break();
		test_random_traffic();
		in_valid <= 1'b0;
		while (expected_best_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/npcs_pkg.sv
rtl/core/npcs_ram.sv
rtl/core/npcs_datapath.sv
rtl/core/npcs_ctrl.sv
rtl/core/nearest_palette_colour_search_core.sv
rtl/core/npcs_checker.sv
dv/tb_nearest_palette_colour_search_core.sv
